// File: hdl/lras_pkg.sv
// ----------------------------------------------------------------------------
// lras_pkg
// Shared types and constants for the lazy range-assign / range-sum tree.
// ----------------------------------------------------------------------------
`default_nettype none

package lras_pkg;

   // tree geometry
   localparam int LEAVES  = 1024;
   localparam int LEAF_W  = $clog2(LEAVES);
   localparam int TREE_W  = 1 << LEAF_W;
   localparam int NODES   = 2 * TREE_W;
   localparam int NODE_W  = LEAF_W + 1;
   localparam int LOOP_W  = LEAF_W + 2;
   localparam int H_W     = $clog2(LEAF_W + 1);

   // field widths
   localparam int LEFT_W  = 10;
   localparam int RIGHT_W = 11;
   localparam int VAL_W   = 32;
   localparam int SUM_W   = 43;
   localparam int OUT_W   = 42;
   localparam int PEND_W  = VAL_W + 1;

   // action codes
   localparam logic ACT_ASSIGN = 1'b0;
   localparam logic ACT_SUM    = 1'b1;

   typedef struct packed {
      logic                     action;
      logic [LEFT_W-1:0]        left;
      logic [RIGHT_W-1:0]       right;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0]  sum;
      logic                     range_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_PUSH_RD,
      ST_PUSH_CHK,
      ST_PUSH_WB,
      ST_PUSH_WC,
      ST_LOOP_INIT,
      ST_LOOP_L,
      ST_LOOP_R,
      ST_BUILD_RD,
      ST_BUILD_WR,
      ST_FIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clr_step;
      logic latch;
      logic push_rd;
      logic push_wa;
      logic push_wb;
      logic push_wc;
      logic path_dn;
      logic loop_init;
      logic loop_l;
      logic loop_r;
      logic bld_init;
      logic bld_rd;
      logic bld_wr;
      logic path_up;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
      logic err;
      logic is_sum;
      logic flag;
      logic side;
      logic h_one;
      logic h_top;
      logic l_lt_r;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// File: hdl/lras_ctrl.sv
// ----------------------------------------------------------------------------
// lras_ctrl
// Sequencer: push-down along both boundary paths, bottom-up range walk,
// parent rebuild for assigns, then result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lras_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output lras_pkg::cmd_type       cmd,
   input  wire lras_pkg::stat_type stat
);
   import lras_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:     if (stat.clr_done) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_START;
         ST_START:     state_in = stat.err ? ST_FIN : ST_PUSH_RD;
         ST_PUSH_RD:   state_in = ST_PUSH_CHK;
         ST_PUSH_CHK: begin
            if (stat.flag) state_in = ST_PUSH_WB;
            else if (stat.side && stat.h_one) state_in = ST_LOOP_INIT;
            else state_in = ST_PUSH_RD;
         end
         ST_PUSH_WB:   state_in = ST_PUSH_WC;
         ST_PUSH_WC: begin
            if (stat.side && stat.h_one) state_in = ST_LOOP_INIT;
            else state_in = ST_PUSH_RD;
         end
         ST_LOOP_INIT: state_in = ST_LOOP_L;
         ST_LOOP_L: begin
            if (stat.l_lt_r) state_in = ST_LOOP_R;
            else if (stat.is_sum) state_in = ST_FIN;
            else state_in = ST_BUILD_RD;
         end
         ST_LOOP_R:    state_in = ST_LOOP_L;
         ST_BUILD_RD:  state_in = ST_BUILD_WR;
         ST_BUILD_WR:  state_in = (stat.side && stat.h_top) ? ST_FIN : ST_BUILD_RD;
         ST_FIN:       if (stat.rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_CLEAR;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR:     cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.latch = req_valid;
         end
         ST_START:     cmd = '0;
         ST_PUSH_RD:   cmd.push_rd = 1'b1;
         ST_PUSH_CHK: begin
            if (stat.flag) cmd.push_wa = 1'b1;
            else cmd.path_dn = 1'b1;
         end
         ST_PUSH_WB:   cmd.push_wb = 1'b1;
         ST_PUSH_WC: begin
            cmd.push_wc = 1'b1;
            cmd.path_dn = 1'b1;
         end
         ST_LOOP_INIT: cmd.loop_init = 1'b1;
         ST_LOOP_L: begin
            if (stat.l_lt_r) cmd.loop_l = 1'b1;
            else if (!stat.is_sum) cmd.bld_init = 1'b1;
         end
         ST_LOOP_R:    cmd.loop_r = 1'b1;
         ST_BUILD_RD:  cmd.bld_rd = 1'b1;
         ST_BUILD_WR: begin
            cmd.bld_wr  = 1'b1;
            cmd.path_up = 1'b1;
         end
         ST_FIN:       cmd.rsp_load = stat.rsp_free;
         default:      cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/lras_dp.sv
// ----------------------------------------------------------------------------
// lras_dp
// Datapath: node-sum and pending-assignment memories, path and walk
// counters, sum accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lras_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lras_pkg::cmd_type  cmd,
   output lras_pkg::stat_type      stat,
   input  wire lras_pkg::req_type  req_data,
   output logic                    rsp_valid,
   output lras_pkg::rsp_type       rsp_data,
   input  wire logic               rsp_stall
);
   import lras_pkg::*;

   // sign-extend an element value and scale by a power-of-two length
   function automatic logic [SUM_W-1:0] fill(input logic [VAL_W-1:0] v,
                                             input logic [H_W-1:0] sh);
      logic [SUM_W-1:0] ext;
      ext = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
      return ext << sh;
   endfunction

   logic [SUM_W-1:0]   sum_mem  [NODES];
   logic [PEND_W-1:0]  pend_mem [TREE_W];

   logic               act_ff;
   logic               err_ff;
   logic [LEAF_W-1:0]  lo_ff;
   logic [LEAF_W-1:0]  hi_ff;
   logic [VAL_W-1:0]   val_ff;
   logic [H_W-1:0]     h_ff;
   logic               side_ff;
   logic [LOOP_W-1:0]  nl_ff;
   logic [LOOP_W-1:0]  nr_ff;
   logic [SUM_W-1:0]   acc_ff;
   logic               acc_add_ff;
   logic [NODE_W-1:0]  clr_ff;
   logic [SUM_W-1:0]   sum_a_rd_ff;
   logic [SUM_W-1:0]   sum_b_rd_ff;
   logic [PEND_W-1:0]  pend_rd_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [NODE_W-1:0]  path_node;
   logic [LEAF_W-1:0]  pidx;
   logic [NODE_W-1:0]  child0;
   logic [NODE_W-1:0]  child1;
   logic [LOOP_W-1:0]  nr_m1;
   logic [NODE_W-1:0]  op_node;
   logic               op_en;
   logic [H_W-1:0]     h_m1;
   logic [LOOP_W-1:0]  nl_in;
   logic [LOOP_W-1:0]  nr_in;

   logic               sum_we;
   logic [NODE_W-1:0]  sum_wa;
   logic [SUM_W-1:0]   sum_wd;
   logic               pend_we;
   logic [LEAF_W-1:0]  pend_wa;
   logic [PEND_W-1:0]  pend_wd;
   logic               sum_a_re;
   logic [NODE_W-1:0]  sum_a_ra;
   logic               pend_re;

   // boundary path node at the current height
   always_comb begin
      path_node = {1'b1, (side_ff ? hi_ff : lo_ff)} >> h_ff;
      pidx      = path_node[LEAF_W-1:0];
      child0    = {pidx, 1'b0};
      child1    = {pidx, 1'b1};
      h_m1      = h_ff - H_W'(1);
   end

   // node touched by the bottom-up walk
   always_comb begin
      nr_m1   = nr_ff - LOOP_W'(1);
      op_en   = (cmd.loop_l && nl_ff[0]) || (cmd.loop_r && nr_ff[0]);
      op_node = cmd.loop_r ? nr_m1[NODE_W-1:0] : nl_ff[NODE_W-1:0];
   end

   // memory write selection
   always_comb begin
      sum_we  = 1'b0;
      sum_wa  = child0;
      sum_wd  = '0;
      pend_we = 1'b0;
      pend_wa = pidx;
      pend_wd = '0;
      if (cmd.clr_step) begin
         sum_we  = 1'b1;
         sum_wa  = clr_ff;
         pend_we = !clr_ff[NODE_W-1];
         pend_wa = clr_ff[LEAF_W-1:0];
      end else if (cmd.push_wa || cmd.push_wb) begin
         sum_we  = 1'b1;
         sum_wa  = cmd.push_wb ? child1 : child0;
         sum_wd  = fill(pend_rd_ff[VAL_W-1:0], h_m1);
         pend_we = (h_ff > H_W'(1));
         pend_wa = cmd.push_wb ? child1[LEAF_W-1:0] : child0[LEAF_W-1:0];
         pend_wd = {1'b1, pend_rd_ff[VAL_W-1:0]};
      end else if (cmd.push_wc) begin
         pend_we = 1'b1;
         pend_wa = pidx;
      end else if (op_en && (act_ff == ACT_ASSIGN)) begin
         sum_we  = 1'b1;
         sum_wa  = op_node;
         sum_wd  = fill(val_ff, h_ff);
         pend_we = !op_node[NODE_W-1];
         pend_wa = op_node[LEAF_W-1:0];
         pend_wd = {1'b1, val_ff};
      end else if (cmd.bld_wr) begin
         sum_we  = !pend_rd_ff[PEND_W-1];
         sum_wa  = path_node;
         sum_wd  = sum_a_rd_ff + sum_b_rd_ff;
      end
   end

   // memory read selection
   always_comb begin
      sum_a_re = cmd.bld_rd || (op_en && (act_ff == ACT_SUM));
      sum_a_ra = cmd.bld_rd ? child0 : op_node;
      pend_re  = cmd.push_rd || cmd.bld_rd;
   end

   // memories
   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_wa] <= sum_wd;
      if (sum_a_re) sum_a_rd_ff <= sum_mem[sum_a_ra];
      if (cmd.bld_rd) sum_b_rd_ff <= sum_mem[child1];
   end

   always_ff @(posedge clock) begin
      if (pend_we) pend_mem[pend_wa] <= pend_wd;
      if (pend_re) pend_rd_ff <= pend_mem[pidx];
   end

   // walk bounds next value
   always_comb begin
      nl_in = nl_ff;
      nr_in = nr_ff;
      if (cmd.loop_init) begin
         nl_in = LOOP_W'({1'b1, lo_ff});
         nr_in = LOOP_W'({1'b1, hi_ff}) + LOOP_W'(1);
      end else if (cmd.loop_l) begin
         if (nl_ff[0]) nl_in = nl_ff + LOOP_W'(1);
      end else if (cmd.loop_r) begin
         nl_in = nl_ff >> 1;
         nr_in = (nr_ff[0] ? nr_m1 : nr_ff) >> 1;
      end
   end

   // item fields, height, side, walk bounds
   always_ff @(posedge clock) begin
      nl_ff <= nl_in;
      nr_ff <= nr_in;
      if (cmd.latch) begin
         act_ff  <= req_data.action;
         lo_ff   <= LEAF_W'(req_data.left);
         hi_ff   <= LEAF_W'(req_data.right - RIGHT_W'(1));
         val_ff  <= req_data.value;
         err_ff  <= (RIGHT_W'(req_data.left) >= req_data.right)
                    || (req_data.right > RIGHT_W'(LEAVES));
         h_ff    <= H_W'(LEAF_W);
         side_ff <= 1'b0;
      end else if (cmd.path_dn) begin
         side_ff <= !side_ff;
         if (side_ff) h_ff <= h_m1;
      end else if (cmd.path_up) begin
         side_ff <= !side_ff;
         if (side_ff) h_ff <= h_ff + H_W'(1);
      end else if (cmd.loop_init) begin
         h_ff <= '0;
      end else if (cmd.loop_r) begin
         h_ff <= h_ff + H_W'(1);
      end else if (cmd.bld_init) begin
         h_ff    <= H_W'(1);
         side_ff <= 1'b0;
      end
   end

   // clearing sweep counter and sum accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         acc_add_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + NODE_W'(1);
         acc_add_ff <= op_en && (act_ff == ACT_SUM);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         acc_ff <= '0;
      end else if (acc_add_ff) begin
         acc_ff <= acc_ff + sum_a_rd_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff.sum         <= ((act_ff == ACT_SUM) && !err_ff)
                                    ? $signed(acc_ff[OUT_W-1:0]) : '0;
         rsp_data_ff.range_error <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status
   always_comb begin
      stat.clr_done = (clr_ff == NODE_W'(NODES - 1));
      stat.err      = err_ff;
      stat.is_sum   = (act_ff == ACT_SUM);
      stat.flag     = pend_rd_ff[PEND_W-1];
      stat.side     = side_ff;
      stat.h_one    = (h_ff == H_W'(1));
      stat.h_top    = (h_ff == H_W'(LEAF_W));
      stat.l_lt_r   = (nl_ff < nr_ff);
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

endmodule

`default_nettype wire

// File: hdl/lazy_range_assign_sum_tree.sv
// ----------------------------------------------------------------------------
// lazy_range_assign_sum_tree
// Range assign / range sum over LEAVES signed elements held in a lazy
// segment tree, built as a sequencer over one node-sum and one
// pending-assignment memory.
//
//   channel   ports                    moves
//   request   req_valid / req_stall    action, left, right, value
//   response  rsp_valid / rsp_stall    sum, range_error
//
// An item walks both boundary paths top-down, pushing any pending
// assignment down to both children, then the bottom-up range walk;
// assigns add a rebuild per node on both paths. Each child is written in
// its own step, set by the single write port of each memory; an item
// with a bad range skips the walks.
// After reset a clearing pass zeroes the memories before the first transfer.
// A stalled response holds; the next item is taken meanwhile and waits for the
// response register before finishing.
// ----------------------------------------------------------------------------
`default_nettype none

module lazy_range_assign_sum_tree (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lras_pkg::req_type req_data,
   output logic                   rsp_valid,
   output lras_pkg::rsp_type      rsp_data,
   input  wire logic              rsp_stall
);
   import lras_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   lras_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // memories and arithmetic
   lras_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire
